// ===== design/tsop_pkg.sv =====
`timescale 1ns / 1ps

package tsop_pkg;

   // TCP option kinds and fixed lengths
   localparam logic [7:0] OPT_KIND_EOL    = 8'd0;
   localparam logic [7:0] OPT_KIND_NOP    = 8'd1;
   localparam logic [7:0] OPT_KIND_MSS    = 8'd2;
   localparam logic [7:0] OPT_KIND_WSCALE = 8'd3;
   localparam logic [7:0] OPT_MSS_SIZE    = 8'd4;
   localparam logic [7:0] OPT_WSCALE_SIZE = 8'd3;
   localparam logic [7:0] OPT_HDR_SIZE    = 8'd2;

   localparam logic [5:0] POS_MAX = 6'd63;

   typedef enum logic [1:0] {
      PH_KIND = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_STOP = 2'd3
   } tsop_phase_type;

   // one options byte with its side information
   typedef struct packed {
      logic       first;
      logic       last;
      logic [5:0] area_len;
      logic [7:0] opt_byte;
   } tsop_item_type;

   // one parse result; mss_seen ends up in the lowest bit
   typedef struct packed {
      logic [7:0]  wscale_value;
      logic        wscale_seen;
      logic [15:0] mss_value;
      logic        mss_seen;
   } tsop_result_type;

   // input stage to parser handoff
   typedef struct packed {
      logic          valid;
      tsop_item_type item;
   } tsop_stage_type;

endpackage

// ===== design/tsop_in_reg.sv =====
`timescale 1ns / 1ps

module tsop_in_reg
   import tsop_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  tsop_item_type  in_item,
   input  logic           take,
   output tsop_stage_type stage
);

   logic          valid_ff, valid_in;
   tsop_item_type item_ff, item_in;

   // accept when empty or when the held word moves on this cycle
   assign in_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            item_in = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ===== design/tsop_parser.sv =====
`timescale 1ns / 1ps

module tsop_parser
   import tsop_pkg::*;
#(
   parameter int MAX_OPTION_BYTES = 40
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  tsop_item_type   item,
   output tsop_result_type result
);

   localparam logic [5:0] AREA_MAX = 6'(MAX_OPTION_BYTES);

   tsop_phase_type phase_ff, phase_in, phase_nx, phase_b;
   logic [5:0]  pos_ff, pos_in, pos_b, pos_nx;
   logic [7:0]  kind_ff, kind_in, kind_b, kind_nx;
   logic [7:0]  len_ff, len_in, len_b, len_nx;
   logic [7:0]  left_ff, left_in, left_b, left_nx;
   logic [7:0]  high_ff, high_in, high_b, high_nx;
   logic [15:0] mss_ff, mss_in, mss_b, mss_nx;
   logic        mflag_ff, mflag_in, mflag_b, mflag_nx;
   logic [7:0]  ws_ff, ws_in, ws_b, ws_nx;
   logic        wflag_ff, wflag_in, wflag_b, wflag_nx;

   logic [7:0] b;
   logic [5:0] area;
   logic       out_area, kind_room, len_bad, mss_opt, ws_opt, active;
   logic [8:0] len_end;
   logic [7:0] idx, left_dec;

   // a first byte starts from the cleared state
   always_comb begin
      phase_b = item.first ? PH_KIND : phase_ff;
      pos_b   = item.first ? 6'd0    : pos_ff;
      kind_b  = item.first ? 8'd0    : kind_ff;
      len_b   = item.first ? 8'd0    : len_ff;
      left_b  = item.first ? 8'd0    : left_ff;
      high_b  = item.first ? 8'd0    : high_ff;
      mss_b   = item.first ? 16'd0   : mss_ff;
      mflag_b = item.first ? 1'b0    : mflag_ff;
      ws_b    = item.first ? 8'd0    : ws_ff;
      wflag_b = item.first ? 1'b0    : wflag_ff;
   end

   assign b         = item.opt_byte;
   assign area      = (item.area_len > AREA_MAX) ? AREA_MAX : item.area_len;
   assign out_area  = pos_b >= area;
   assign kind_room = ({1'b0, pos_b} + 7'd1) < {1'b0, area};
   // the kind byte sat one position before the length byte
   assign len_end   = {3'b000, pos_b} - 9'd1 + {1'b0, b};
   assign len_bad   = (b < OPT_HDR_SIZE) || (len_end > {3'b000, area});
   assign idx       = len_b - left_b - OPT_HDR_SIZE;
   assign left_dec  = left_b - 8'd1;
   assign mss_opt   = (kind_b == OPT_KIND_MSS) && (len_b == OPT_MSS_SIZE);
   assign ws_opt    = (kind_b == OPT_KIND_WSCALE) && (len_b == OPT_WSCALE_SIZE);
   assign active    = (phase_b != PH_STOP) && !out_area;

   // next phase
   always_comb begin
      phase_nx = phase_b;
      if (phase_b != PH_STOP && out_area) begin
         phase_nx = PH_STOP;
      end else begin
         case (phase_b)
            PH_KIND: begin
               if (b == OPT_KIND_EOL) begin
                  phase_nx = PH_STOP;
               end else if (b == OPT_KIND_NOP) begin
                  phase_nx = PH_KIND;
               end else if (!kind_room) begin
                  phase_nx = PH_STOP;
               end else begin
                  phase_nx = PH_LEN;
               end
            end
            PH_LEN: begin
               if (len_bad) begin
                  phase_nx = PH_STOP;
               end else if (b == OPT_HDR_SIZE) begin
                  phase_nx = PH_KIND;
               end else begin
                  phase_nx = PH_DATA;
               end
            end
            PH_DATA: begin
               phase_nx = (left_dec == 8'd0) ? PH_KIND : PH_DATA;
            end
            PH_STOP: phase_nx = PH_STOP;
            default: phase_nx = PH_STOP;
         endcase
      end
      if (item.last) begin
         phase_nx = PH_STOP;
      end
   end

   // option fields and stores
   always_comb begin
      kind_nx  = kind_b;
      len_nx   = len_b;
      left_nx  = left_b;
      high_nx  = high_b;
      mss_nx   = mss_b;
      mflag_nx = mflag_b;
      ws_nx    = ws_b;
      wflag_nx = wflag_b;
      if (active) begin
         case (phase_b)
            PH_KIND: begin
               if (b != OPT_KIND_EOL && b != OPT_KIND_NOP && kind_room) begin
                  kind_nx = b;
               end
            end
            PH_LEN: begin
               if (!len_bad) begin
                  len_nx  = b;
                  left_nx = b - OPT_HDR_SIZE;
               end
            end
            PH_DATA: begin
               left_nx = left_dec;
               if (mss_opt) begin
                  if (idx == 8'd0) begin
                     high_nx = b;
                  end else if (idx == 8'd1) begin
                     mss_nx   = {high_b, b};
                     mflag_nx = 1'b1;
                  end
               end else if (ws_opt && idx == 8'd0) begin
                  ws_nx    = b;
                  wflag_nx = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (item.last) begin
         pos_nx = 6'd0;
      end else begin
         pos_nx = (pos_b == POS_MAX) ? pos_b : pos_b + 6'd1;
      end
   end

   // hold everything when no byte advances
   assign phase_in = step ? phase_nx : phase_ff;
   assign pos_in   = step ? pos_nx   : pos_ff;
   assign kind_in  = step ? kind_nx  : kind_ff;
   assign len_in   = step ? len_nx   : len_ff;
   assign left_in  = step ? left_nx  : left_ff;
   assign high_in  = step ? high_nx  : high_ff;
   assign mss_in   = step ? mss_nx   : mss_ff;
   assign mflag_in = step ? mflag_nx : mflag_ff;
   assign ws_in    = step ? ws_nx    : ws_ff;
   assign wflag_in = step ? wflag_nx : wflag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KIND;
         pos_ff   <= 6'd0;
         kind_ff  <= 8'd0;
         len_ff   <= 8'd0;
         left_ff  <= 8'd0;
         high_ff  <= 8'd0;
         mss_ff   <= 16'd0;
         mflag_ff <= 1'b0;
         ws_ff    <= 8'd0;
         wflag_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         high_ff  <= high_in;
         mss_ff   <= mss_in;
         mflag_ff <= mflag_in;
         ws_ff    <= ws_in;
         wflag_ff <= wflag_in;
      end
   end

   assign result.mss_seen     = mflag_nx;
   assign result.mss_value    = mss_nx;
   assign result.wscale_seen  = wflag_nx;
   assign result.wscale_value = ws_nx;

endmodule

// ===== design/tsop_out_reg.sv =====
`timescale 1ns / 1ps

module tsop_out_reg
   import tsop_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  tsop_result_type result,
   output logic            free,
   output logic            out_valid,
   input  logic            out_ready,
   output tsop_result_type out_result
);

   logic            valid_ff, valid_in;
   tsop_result_type result_ff, result_in;

   // slot is free when empty or drained this cycle
   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== design/tcp_syn_option_parser.sv =====
`timescale 1ns / 1ps

// TCP SYN option parser: walks the options area of a TCP header and reports
// the peer MSS and window-scale options.
//
// Input channel (req_): one options byte per word. req_tlast marks the final
// byte of the area, req_tuser[0] marks the first byte and clears the parser.
// Output channel (rsp_): one result word per byte that carried tlast.
//
// Result path: a byte with tlast waits in the input register; the edge that
// steps it on loads its result into the result register behind rsp_tvalid.
// Throughput: one byte per cycle while no tlast byte waits on a full result
// slot; the parse step for a byte is a single pass of shallow logic between
// the input register and the parser state.
//
// Reset: all parser state, flags and stores clear, both channels empty;
// the block behaves as if a first byte had just arrived.
// Stall: a result waits in the result register while rsp_tready is low;
// bytes without tlast keep flowing, a byte with tlast holds in the input
// register until the result slot frees, and req_tready stays low meanwhile.
module tcp_syn_option_parser
   import tsop_pkg::*;
#(
   parameter int MAX_OPTION_BYTES = 40
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] opt_byte, [13:8] area_len, [15:14] zero
   input  logic [0:0]  req_tuser,  // [0] first
   input  logic        req_tlast,  // last byte of the options area
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [0] mss_seen, [16:1] mss_value,
                                   // [17] wscale_seen, [25:18] wscale_value,
                                   // [31:26] zero
);

   tsop_item_type   req_item;
   tsop_stage_type  stage;
   tsop_result_type result, rsp_result;
   logic            step, out_free;

   // unpack the request word
   assign req_item.first    = req_tuser[0];
   assign req_item.last     = req_tlast;
   assign req_item.area_len = req_tdata[13:8];
   assign req_item.opt_byte = req_tdata[7:0];

   // advance a byte unless it would emit into a full result slot
   assign step = stage.valid && (!stage.item.last || out_free);

   tsop_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (req_item),
      .take     (step),
      .stage    (stage)
   );

   tsop_parser #(
      .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (stage.item),
      .result (result)
   );

   tsop_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step && stage.item.last),
      .result     (result),
      .free       (out_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {6'b000000, rsp_result};

endmodule

// ===== design/tsop_checker.sv =====
`timescale 1ns / 1ps

module tsop_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped under stall");

   // a stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed under stall");

   // no MSS found means no stale MSS value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[16:1] == 16'd0)
      else $error("mss_value set without mss_seen");

   // no window scale found means no stale shift
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[17] |-> rsp_tdata[25:18] == 8'd0)
      else $error("wscale_value set without wscale_seen");

   // reset empties the result register
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind tcp_syn_option_parser tsop_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Byte-stream check of the TCP SYN option parser: one options byte per req_
// word, one result word per byte that carries tlast. A software copy of the
// parser tracks every accepted byte and queues the result each last byte
// must produce; the rsp_ side compares every result word against it.
module tb;
   import tsop_pkg::*;

   localparam int MAX_OPTION_BYTES = 40;
   localparam int QUIET_LIMIT      = 2000;  // cycles with no word moving
   localparam int TAIL_CYCLES      = 12;    // settle time after the last result
   localparam int HOLD_CYCLES      = 250;   // long receiver back-pressure
   localparam int HOLD_AT_BYTE     = 1200;
   localparam int RANDOM_BYTES     = 1800;

   typedef logic [7:0] octet_type;

   // one pending stimulus entry; a pause entry stops the sender until
   // every owed result has come back
   typedef struct {
      tsop_item_type item;
      bit            pause;
   } option_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] opt_byte, [13:8] area_len, [15:14] zero
   logic [0:0]  req_tuser = '0;   // [0] first
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [0] mss_seen, [16:1] mss_value,
                                  // [17] wscale_seen, [25:18] wscale_value

   tsop_result_type rsp_word;
   assign rsp_word = rsp_tdata[25:0];

   tcp_syn_option_parser #(
      .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Parser shadow: state starts at its reset values, reset is applied once
   // ---------------------------------------------------------------------
   logic [5:0]     pos_cnt     = '0;
   tsop_phase_type phase       = PH_KIND;
   octet_type      opt_kind    = '0;
   octet_type      opt_len     = '0;
   octet_type      len_left    = '0;
   octet_type      mss_hi      = '0;
   logic [15:0]    mss_hold    = '0;
   logic           mss_found   = 1'b0;
   octet_type      ws_hold     = '0;
   logic           ws_found    = 1'b0;

   option_slot_type byte_queue[$];
   tsop_result_type owed_results[$];
   int unsigned     owed_cnt   = 0;   // results predicted, driver side
   int unsigned     seen_cnt   = 0;   // results accepted, monitor side
   int unsigned     bytes_in   = 0;   // option bytes accepted
   int unsigned     cyc        = 0;
   int unsigned     quiet      = 0;
   int              mismatches = 0;
   bit              pause_wait = 1'b0;

   // full-rate stretch: neither side inserts random gaps here
   wire no_gaps = (cyc >= 300) && (cyc < 800);

   // Advance the shadow parser by one options byte; return 1 when the byte
   // closes a header and hand back the result it must produce.
   function automatic bit parse_option_byte(input tsop_item_type w,
                                            output tsop_result_type r);
      int area;
      int pos;
      int idx;
      area = (w.area_len > MAX_OPTION_BYTES) ? MAX_OPTION_BYTES : int'(w.area_len);
      if (w.first) begin
         pos_cnt   = '0;
         phase     = PH_KIND;
         opt_kind  = '0;
         opt_len   = '0;
         len_left  = '0;
         mss_hi    = '0;
         mss_hold  = '0;
         mss_found = 1'b0;
         ws_hold   = '0;
         ws_found  = 1'b0;
      end
      pos = pos_cnt;
      // a stopped parser ignores everything until the next first byte
      if (phase != PH_STOP) begin
         if (pos >= area) begin
            // byte lies outside the options area
            phase = PH_STOP;
         end else begin
            case (phase)
               PH_KIND: begin
                  if (w.opt_byte == OPT_KIND_EOL) begin
                     phase = PH_STOP;
                  end else if (w.opt_byte == OPT_KIND_NOP) begin
                     phase = PH_KIND;
                  end else if (pos + 1 >= area) begin
                     // no room left for the length byte
                     phase = PH_STOP;
                  end else begin
                     opt_kind = w.opt_byte;
                     phase    = PH_LEN;
                  end
               end
               PH_LEN: begin
                  // the kind byte sat one position back
                  if (w.opt_byte < OPT_HDR_SIZE ||
                      (pos - 1) + int'(w.opt_byte) > area) begin
                     phase = PH_STOP;
                  end else begin
                     opt_len  = w.opt_byte;
                     len_left = w.opt_byte - OPT_HDR_SIZE;
                     phase    = (len_left == 0) ? PH_KIND : PH_DATA;
                  end
               end
               default: begin
                  idx = int'(opt_len) - int'(len_left) - int'(OPT_HDR_SIZE);
                  if (opt_kind == OPT_KIND_MSS && opt_len == OPT_MSS_SIZE) begin
                     if (idx == 0) begin
                        mss_hi = w.opt_byte;
                     end else if (idx == 1) begin
                        mss_hold  = {mss_hi, w.opt_byte};
                        mss_found = 1'b1;
                     end
                  end else if (opt_kind == OPT_KIND_WSCALE &&
                               opt_len == OPT_WSCALE_SIZE) begin
                     if (idx == 0) begin
                        ws_hold  = w.opt_byte;
                        ws_found = 1'b1;
                     end
                  end
                  len_left = len_left - 8'd1;
                  if (len_left == 0) begin
                     phase = PH_KIND;
                  end
               end
            endcase
         end
      end
      if (pos_cnt < POS_MAX) begin
         pos_cnt = pos_cnt + 6'd1;
      end
      r = '0;
      if (!w.last) begin
         return 1'b0;
      end
      r.mss_seen     = mss_found;
      r.mss_value    = mss_hold;
      r.wscale_seen  = ws_found;
      r.wscale_value = ws_hold;
      phase   = PH_STOP;
      pos_cnt = '0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Queue one header's bytes; bytes from alt_from on carry alt_area.
   task automatic stage_header(input logic [5:0] area, input logic [5:0] alt_area,
                               input int alt_from, input bit with_first,
                               input octet_type b[$]);
      option_slot_type s;
      for (int i = 0; i < b.size(); i++) begin
         s.pause         = 1'b0;
         s.item.opt_byte = b[i];
         s.item.area_len = (i >= alt_from) ? alt_area : area;
         s.item.first    = with_first && (i == 0);
         s.item.last     = (i == b.size() - 1);
         byte_queue.push_back(s);
      end
   endtask

   // Fill an options area of the given length with well-formed options.
   task automatic build_options(input int area, output octet_type q[$]);
      int        room;
      int        roll;
      int        len;
      octet_type k;
      q = {};
      while (q.size() < area) begin
         room = area - q.size();
         roll = $urandom_range(99);
         if (roll < 25 && room >= 4) begin
            q.push_back(OPT_KIND_MSS);
            q.push_back(OPT_MSS_SIZE);
            q.push_back(octet_type'($urandom_range(255)));
            q.push_back(octet_type'($urandom_range(255)));
         end else if (roll < 45 && room >= 3) begin
            q.push_back(OPT_KIND_WSCALE);
            q.push_back(OPT_WSCALE_SIZE);
            q.push_back(octet_type'($urandom_range(255)));
         end else if (roll < 75 && room >= 2) begin
            // mostly unknown kinds; sometimes MSS or window scale with a random
            // length, which is skipped unless it matches that option's size
            k   = ($urandom_range(3) == 0) ? octet_type'($urandom_range(3, 2))
                                           : octet_type'($urandom_range(255, 4));
            len = $urandom_range((room < 10) ? room : 10, 2);
            q.push_back(k);
            q.push_back(octet_type'(len));
            repeat (len - 2) q.push_back(octet_type'($urandom_range(255)));
         end else if (roll < 82) begin
            // end of list, then padding that must be ignored
            q.push_back(OPT_KIND_EOL);
            while (q.size() < area) q.push_back(octet_type'($urandom_range(255)));
         end else begin
            q.push_back(OPT_KIND_NOP);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: feed option bytes from byte_queue, predict on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive
      option_slot_type slot;
      tsop_result_type due;
      if (reset) begin
         req_tvalid <= 1'b0;
         pause_wait <= 1'b0;
      end else begin
         // a word moved on this edge: advance the shadow parser
         if (req_tvalid && req_tready) begin
            bytes_in <= bytes_in + 1;
            if (parse_option_byte({req_tuser[0], req_tlast, req_tdata[13:0]}, due)) begin
               owed_results.push_back(due);
               owed_cnt <= owed_cnt + 1;
            end
         end
         if (pause_wait) begin
            // hold off until every owed result has been seen
            if (owed_cnt == seen_cnt) begin
               pause_wait <= 1'b0;
            end
         end else if (!req_tvalid || req_tready) begin
            if (byte_queue.size() == 0 || (!no_gaps && $urandom_range(99) < 11)) begin
               req_tvalid <= 1'b0;
            end else begin
               slot = byte_queue.pop_front();
               if (slot.pause) begin
                  req_tvalid <= 1'b0;
                  pause_wait <= 1'b1;
               end else begin
                  req_tvalid <= 1'b1;
                  req_tdata  <= {2'b00, slot.item.area_len, slot.item.opt_byte};
                  req_tuser  <= slot.item.first;
                  req_tlast  <= slot.item.last;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: accept result words, compare against the oldest owed result
   // ---------------------------------------------------------------------
   task automatic flag_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      tsop_result_type want;
      int unsigned     hold_left;
      bit              hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_cnt <= seen_cnt + 1;
            if (owed_results.size() == 0) begin
               $display("%0t ns: result word with none expected, expected none, actual %0h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               flag_field("mss_seen", 16'(want.mss_seen), 16'(rsp_word.mss_seen));
               flag_field("mss_value", want.mss_value, rsp_word.mss_value);
               flag_field("wscale_seen", 16'(want.wscale_seen), 16'(rsp_word.wscale_seen));
               flag_field("wscale_value", 16'(want.wscale_value),
                          16'(rsp_word.wscale_value));
            end
         end
         // one long stall so the block backs up into its input
         if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || ($urandom_range(99) >= 11);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run when no word moves for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("tcp_syn_option_parser regression: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      octet_type       hdr[$];
      option_slot_type s;
      int              rand_bytes;
      int              roll;
      int              n;
      int              area;
      logic [5:0]      area_sent;
      logic [5:0]      alt_area;
      int              alt_from;
      bit              with_first;
      bit              paused_mid;

      // Directed part.
      // last byte right after reset with no first byte: empty result
      hdr = {OPT_KIND_MSS};
      stage_header(6'd4, 6'd4, 99, 1'b0, hdr);
      // largest MSS and shift, closed by end of list
      hdr = {OPT_KIND_MSS, OPT_MSS_SIZE, 8'hFF, 8'hFF,
             OPT_KIND_WSCALE, OPT_WSCALE_SIZE, 8'hFF, OPT_KIND_EOL};
      stage_header(6'd8, 6'd8, 99, 1'b1, hdr);
      // no-op, zero shift, zero MSS
      hdr = {OPT_KIND_NOP, OPT_KIND_WSCALE, OPT_WSCALE_SIZE, 8'h00,
             OPT_KIND_MSS, OPT_MSS_SIZE, 8'h00, 8'h00};
      stage_header(6'd8, 6'd8, 99, 1'b1, hdr);
      // kind byte with no room for its length
      hdr = {OPT_KIND_NOP, OPT_KIND_MSS};
      stage_header(6'd2, 6'd2, 99, 1'b1, hdr);
      // length below two
      hdr = {OPT_KIND_WSCALE, 8'h01, OPT_KIND_WSCALE};
      stage_header(6'd3, 6'd3, 99, 1'b1, hdr);
      // length running past the area
      hdr = {8'h1E, 8'h04, 8'hAA};
      stage_header(6'd3, 6'd3, 99, 1'b1, hdr);
      // empty area, then an area length beyond the maximum
      hdr = {OPT_KIND_WSCALE};
      stage_header(6'd0, 6'd0, 99, 1'b1, hdr);
      hdr = {OPT_KIND_NOP};
      stage_header(6'd63, 6'd63, 99, 1'b1, hdr);
      // drain before the random part
      s.pause = 1'b1;
      s.item  = '0;
      byte_queue.push_back(s);

      // Random part: mostly well-formed headers, some broken, some noise.
      rand_bytes = 0;
      paused_mid = 1'b0;
      while (rand_bytes < RANDOM_BYTES) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            // loose bytes with random flags and area lengths
            n = $urandom_range(6, 1);
            repeat (n) begin
               s.pause         = 1'b0;
               s.item.opt_byte = octet_type'($urandom_range(255));
               s.item.area_len = 6'($urandom_range(63));
               s.item.first    = ($urandom_range(3) == 0);
               s.item.last     = ($urandom_range(2) == 0);
               byte_queue.push_back(s);
            end
            rand_bytes += n;
         end else begin
            area = $urandom_range(40, 1);
            build_options(area, hdr);
            area_sent  = 6'(area);
            alt_area   = 6'(area);
            alt_from   = hdr.size();
            with_first = 1'b1;
            if (roll >= 75) begin
               case ($urandom_range(5))
                  0: hdr[$urandom_range(hdr.size() - 1)] = octet_type'($urandom_range(255));
                  1: begin
                     // cut the header short, often inside an option
                     n = $urandom_range(hdr.size(), 1);
                     while (hdr.size() > n) void'(hdr.pop_back());
                  end
                  2: begin
                     // area length changes partway through
                     alt_area = 6'($urandom_range(63));
                     alt_from = $urandom_range(hdr.size() - 1);
                  end
                  3: begin
                     area_sent = ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(63, 41));
                     alt_area  = area_sent;
                  end
                  4: with_first = 1'b0;
                  default: repeat ($urandom_range(4, 1))
                     hdr.push_back(octet_type'($urandom_range(255)));
               endcase
            end
            stage_header(area_sent, alt_area, alt_from, with_first, hdr);
            rand_bytes += hdr.size();
         end
         // one sender pause partway through
         if (!paused_mid && rand_bytes >= RANDOM_BYTES / 2) begin
            paused_mid = 1'b1;
            s.pause = 1'b1;
            s.item  = '0;
            byte_queue.push_back(s);
         end
      end

      // release reset once the stimulus is queued
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // drain stimulus, then owed results, then settle
      while (byte_queue.size() != 0 || req_tvalid || pause_wait) @(negedge clock);
      while (owed_cnt > seen_cnt) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("tcp_syn_option_parser regression: pass");
      end else begin
         $display("tcp_syn_option_parser regression: fail");
      end
      $finish;
   end

endmodule

// ===== tcp_syn_option_parser.f =====
design/tsop_pkg.sv
design/tsop_in_reg.sv
design/tsop_parser.sv
design/tsop_out_reg.sv
design/tcp_syn_option_parser.sv
design/tsop_checker.sv
tb/tb.sv
